>>> sv/igm_pkg.sv
// Package for the image gradient magnitude core.
// Holds the transaction payload types, opcodes, register indexes, sizes and the sequencer states.
// No dependencies.
package igm_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int COORD_W    = 8;
	localparam int PIX_W      = 8;
	localparam int SUM_W      = 19;
	localparam int ROOT_STEPS = 10;
	localparam int STEP_W     = 4;

	localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;
	localparam logic [CFG_W-1:0] SIZE_MIN   = 9'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [COORD_W-1:0] x_pos;
		logic [COORD_W-1:0] y_pos;
		logic [PIX_W-1:0]   pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] gradient;
		logic             coord_error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage

>>> sv/image_gradient_magnitude_core.sv
// Top level of the image gradient magnitude core: frame store, read sequencer and shared root unit.
// Depends on igm_pkg and igm_ram.
//
//  Channel   Direction  Handshake             Contents
//  in        in         in_valid/in_ready     igm_pkg::in_item_t (load or query)
//  out       out        out_valid/out_ready   igm_pkg::out_item_t (one per query)
//  cfg       in         cfg_wr_en             cfg_index, cfg_wdata (width, height)
//
// A load is accepted in the idle state. A query inside the frame makes four reads on the single
// read port, squares both differences on the squaring multiplier and runs the digit-by-digit
// square root before the block is ready again. A query outside the frame goes straight to the
// result. Reset sets both sizes to 256; the frame store is not cleared.
// A result waiting in the output register stalls only the next query at its last cycle.
module image_gradient_magnitude_core #(
	parameter int MAX_WIDTH  = igm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = igm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  igm_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output igm_pkg::out_item_t              out_data,
	input  logic                            cfg_wr_en,
	input  logic [igm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [igm_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = igm_pkg::COORD_W;
	localparam int PW    = igm_pkg::PIX_W;
	localparam int SW    = igm_pkg::SUM_W;
	localparam int FW    = igm_pkg::CFG_W;
	localparam int TW    = igm_pkg::STEP_W;

	localparam logic [SW-1:0] ROOT_TOP = SW'(1) << (2 * (igm_pkg::ROOT_STEPS - 1));

	function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] col,
			input logic [CW-1:0] row);
		return AW'(row) * AW'(MAX_WIDTH) + AW'(col);
	endfunction

	igm_pkg::state_t state_q, state_d;
	logic [TW-1:0]   step_q;
	logic [FW-1:0]   width_q, height_q;
	logic            out_valid_q;
	igm_pkg::out_item_t out_data_q;

	logic [CW-1:0]   x_q, y_q;
	logic            lx_q, rx_q, ty_q, by_q;
	logic            err_q;
	logic [PW-1:0]   tap_q [4];
	logic [SW-1:0]   rem_q, res_q, bit_q;

	logic [FW-1:0]   w_eff, h_eff;
	logic            inside_in, at_left_in, at_right_in, at_top_in, at_bottom_in;
	logic            in_fire, query_fire, ram_we, out_load;
	logic [AW-1:0]   waddr, raddr;
	logic [PW-1:0]   rdata;
	logic [CW-1:0]   ax, bx, ay, by;
	logic [1:0]      tap_idx;
	logic [PW-1:0]   da, db, absd;
	logic            border;
	logic [PW:0]     diff, mag;
	logic [2*PW+1:0] sq;
	logic [SW:0]     trial;
	logic            take;
	logic [PW-1:0]   g_sat;

	always_comb begin
		if (width_q < igm_pkg::SIZE_MIN) begin
			w_eff = igm_pkg::SIZE_MIN;
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = FW'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q < igm_pkg::SIZE_MIN) begin
			h_eff = igm_pkg::SIZE_MIN;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = FW'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign inside_in    = ({1'b0, in_data.x_pos} < w_eff) && ({1'b0, in_data.y_pos} < h_eff);
	assign at_left_in   = (in_data.x_pos == '0);
	assign at_right_in  = ({1'b0, in_data.x_pos} == w_eff - FW'(1));
	assign at_top_in    = (in_data.y_pos == '0);
	assign at_bottom_in = ({1'b0, in_data.y_pos} == h_eff - FW'(1));

	assign in_fire    = in_valid && in_ready;
	assign query_fire = in_fire && (in_data.opcode == igm_pkg::OP_QUERY);
	assign ram_we     = in_fire && (in_data.opcode == igm_pkg::OP_LOAD) && inside_in;
	assign waddr      = pix_addr(in_data.x_pos, in_data.y_pos);

	assign ax = rx_q ? x_q : x_q + CW'(1);
	assign bx = lx_q ? x_q : x_q - CW'(1);
	assign ay = by_q ? y_q : y_q + CW'(1);
	assign by = ty_q ? y_q : y_q - CW'(1);

	always_comb begin
		unique case (step_q[1:0])
			2'd0: raddr = pix_addr(ax, y_q);
			2'd1: raddr = pix_addr(bx, y_q);
			2'd2: raddr = pix_addr(x_q, ay);
			default: raddr = pix_addr(x_q, by);
		endcase
	end

	igm_ram #(
		.WIDTH(PW),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(in_data.pixel_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign tap_idx = 2'(step_q - TW'(1));

	assign da     = step_q[0] ? tap_q[2] : tap_q[0];
	assign db     = step_q[0] ? tap_q[3] : tap_q[1];
	assign border = step_q[0] ? (ty_q || by_q) : (lx_q || rx_q);
	assign diff   = {1'b0, da} - {1'b0, db};
	assign absd   = diff[PW] ? PW'(-diff) : diff[PW-1:0];
	assign mag    = border ? {absd, 1'b0} : {1'b0, absd};
	assign sq     = mag * mag;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;

	assign g_sat = (|res_q[SW-1:PW+1]) ? '1 : res_q[PW:1];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			igm_pkg::ST_IDLE: begin
				if (in_valid && in_data.opcode == igm_pkg::OP_QUERY) begin
					state_d = inside_in ? igm_pkg::ST_READ : igm_pkg::ST_DONE;
				end
			end
			igm_pkg::ST_READ: begin
				if (step_q == TW'(4)) begin
					state_d = igm_pkg::ST_SQUARE;
				end
			end
			igm_pkg::ST_SQUARE: begin
				if (step_q == TW'(1)) begin
					state_d = igm_pkg::ST_ROOT;
				end
			end
			igm_pkg::ST_ROOT: begin
				if (step_q == TW'(igm_pkg::ROOT_STEPS - 1)) begin
					state_d = igm_pkg::ST_DONE;
				end
			end
			igm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = igm_pkg::ST_IDLE;
				end
			end
			default: state_d = igm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			igm_pkg::ST_IDLE: in_ready = 1'b1;
			igm_pkg::ST_DONE: out_load = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= igm_pkg::ST_IDLE;
			step_q      <= '0;
			width_q     <= igm_pkg::SIZE_RESET;
			height_q    <= igm_pkg::SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d == state_q && state_q != igm_pkg::ST_IDLE
					&& state_q != igm_pkg::ST_DONE) begin
				step_q <= step_q + TW'(1);
			end else begin
				step_q <= '0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					igm_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
					igm_pkg::REG_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			x_q   <= in_data.x_pos;
			y_q   <= in_data.y_pos;
			lx_q  <= at_left_in;
			rx_q  <= at_right_in && !at_left_in;
			ty_q  <= at_top_in;
			by_q  <= at_bottom_in && !at_top_in;
			err_q <= !inside_in;
			res_q <= '0;
		end
		if (state_q == igm_pkg::ST_READ && step_q != '0) begin
			tap_q[tap_idx] <= rdata;
		end
		if (state_q == igm_pkg::ST_SQUARE) begin
			if (step_q[0]) begin
				rem_q <= rem_q + SW'(sq);
				res_q <= '0;
				bit_q <= ROOT_TOP;
			end else begin
				rem_q <= SW'(sq);
			end
		end
		if (state_q == igm_pkg::ST_ROOT) begin
			if (take) begin
				rem_q <= rem_q - trial[SW-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (out_load) begin
			out_data_q.gradient    <= err_q ? '0 : g_sat;
			out_data_q.coord_error <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == igm_pkg::ST_IDLE)
		else $error("Frame write outside the idle state.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.coord_error |-> out_data.gradient == '0)
		else $error("Coordinate error reported with a nonzero gradient.");

	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == igm_pkg::ST_ROOT |-> $onehot(bit_q))
		else $error("Root trial bit is not one-hot.");

	a_outside_done: assert property (@(posedge clk) disable iff (!arst_n)
		query_fire && !inside_in |=> state_q == igm_pkg::ST_DONE && err_q)
		else $error("Query outside the frame did not go straight to the result.");

endmodule

>>> sv/igm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module igm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
